FILE: rtl/core/bfx_pkg.sv
// Shared types and constants for the byte FIFO with XON/XOFF watermarks.
// Holds the controller state type, the command and status structs and the
// flow control characters. No dependencies.
package bfx_pkg;

    // Default storage depth in bytes
    localparam int unsigned DEF_FIFO_DEPTH = 32;

    // Field widths fixed by the item format
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned MARK_W = 6;
    localparam int unsigned FILL_W = 6;
    localparam int unsigned CFG_IDX_W = 2;

    // Flow control characters
    localparam logic [BYTE_W-1:0] XON_CHAR  = 8'h11;
    localparam logic [BYTE_W-1:0] XOFF_CHAR = 8'h13;

    // Item mode codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK  = 2'd1;

    // Reset values of the watermarks
    localparam logic [MARK_W-1:0] HIGH_MARK_RST = 6'd20;
    localparam logic [MARK_W-1:0] LOW_MARK_RST  = 6'd4;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;   // accept the input transaction and update the FIFO
        logic load;   // move the pending result into the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register empty or being drained this cycle
    } t_status;

endpackage

FILE: rtl/core/bfx_ctrl.sv
// Controller for the byte FIFO: sequences one transaction at a time.
// Depends on bfx_pkg for the state type and the command and status structs.
module bfx_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  bfx_pkg::t_status i_status,
    output logic            o_in_ready,
    output bfx_pkg::t_cmd   o_cmd
);
    import bfx_pkg::*;

    t_state r_state;
    t_state n_state;

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Drive commands and ready
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_DONE: begin
                o_cmd.load = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/bfx_dpath.sv
// Datapath for the byte FIFO: storage, pointers, fill count, watermarks,
// link state and the output register. Depends on bfx_pkg.
module bfx_dpath #(
    parameter int unsigned FIFO_DEPTH = bfx_pkg::DEF_FIFO_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bfx_pkg::t_cmd                   i_cmd,
    output bfx_pkg::t_status                o_status,
    input  logic                            i_cfg_we,
    input  logic [bfx_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfx_pkg::MARK_W-1:0]      i_cfg_data,
    input  logic                            i_mode,
    input  logic [bfx_pkg::BYTE_W-1:0]      i_byte_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bfx_pkg::BYTE_W-1:0]      o_byte_out,
    output logic                            o_byte_valid,
    output logic                            o_send_flow,
    output logic [bfx_pkg::BYTE_W-1:0]      o_flow_char,
    output logic                            o_overflow,
    output logic [bfx_pkg::FILL_W-1:0]      o_fill_level
);
    import bfx_pkg::*;

    localparam int unsigned PW = $clog2(FIFO_DEPTH);
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned XW = (CW > MARK_W) ? CW : MARK_W;
    localparam logic [PW-1:0] LAST_POS = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    logic [BYTE_W-1:0] r_mem [FIFO_DEPTH];

    logic [PW-1:0]     r_wr_pos, n_wr_pos;
    logic [PW-1:0]     r_rd_pos, n_rd_pos;
    logic [CW-1:0]     r_count, n_count;
    logic              r_paused, n_paused;
    logic [MARK_W-1:0] r_high, r_low;

    logic [BYTE_W-1:0] r_rd_data;

    logic              r_pend_valid, n_pend_valid;
    logic              r_pend_send, n_pend_send;
    logic [BYTE_W-1:0] r_pend_char, n_pend_char;
    logic              r_pend_ovf, n_pend_ovf;
    logic [FILL_W-1:0] r_pend_fill, n_pend_fill;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bvalid;
    logic              r_out_send;
    logic [BYTE_W-1:0] r_out_char;
    logic              r_out_ovf;
    logic [FILL_W-1:0] r_out_fill;

    logic              full, empty, do_write, do_read;
    logic [XW-1:0]     count_x;

    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);
    assign do_write = i_cmd.take && (i_mode == MODE_PUSH) && !full;
    assign do_read  = i_cmd.take && (i_mode == MODE_POP) && !empty;

    // Work out the FIFO update and the result flags for an accepted item
    always_comb begin
        n_wr_pos     = r_wr_pos;
        n_rd_pos     = r_rd_pos;
        n_count      = r_count;
        n_paused     = r_paused;
        n_pend_valid = 1'b0;
        n_pend_send  = 1'b0;
        n_pend_char  = '0;
        n_pend_ovf   = 1'b0;
        if (do_write) begin
            n_wr_pos = (r_wr_pos == LAST_POS) ? '0 : r_wr_pos + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (do_read) begin
            n_rd_pos     = (r_rd_pos == LAST_POS) ? '0 : r_rd_pos + 1'b1;
            n_count      = r_count - 1'b1;
            n_pend_valid = 1'b1;
        end
        count_x = XW'(n_count);
        if (i_cmd.take && (i_mode == MODE_PUSH)) begin
            n_pend_ovf = full;
            // XOFF once the level reaches the high watermark
            if ((count_x >= XW'(r_high)) && !r_paused) begin
                n_pend_send = 1'b1;
                n_pend_char = XOFF_CHAR;
                n_paused    = 1'b1;
            end
        end
        if (do_read) begin
            // XON once the level drains to the low watermark
            if ((count_x <= XW'(r_low)) && r_paused) begin
                n_pend_send = 1'b1;
                n_pend_char = XON_CHAR;
                n_paused    = 1'b0;
            end
        end
        n_pend_fill = count_x[FILL_W-1:0];
    end

    // Hold pointers, count, link state and watermarks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_count  <= '0;
            r_paused <= 1'b0;
            r_high   <= HIGH_MARK_RST;
            r_low    <= LOW_MARK_RST;
        end else begin
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
            r_count  <= n_count;
            r_paused <= n_paused;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HIGH_MARK: r_high <= i_cfg_data;
                    REG_LOW_MARK:  r_low  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Byte store: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_wr_pos] <= i_byte_in;
        end
        if (do_read) begin
            r_rd_data <= r_mem[r_rd_pos];
        end
    end

    // Capture the result flags of the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_valid <= n_pend_valid;
            r_pend_send  <= n_pend_send;
            r_pend_char  <= n_pend_char;
            r_pend_ovf   <= n_pend_ovf;
            r_pend_fill  <= n_pend_fill;
        end
    end

    // Output register: load on command, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte   <= r_pend_valid ? r_rd_data : '0;
            r_out_bvalid <= r_pend_valid;
            r_out_send   <= r_pend_send;
            r_out_char   <= r_pend_char;
            r_out_ovf    <= r_pend_ovf;
            r_out_fill   <= r_pend_fill;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_byte_out   = r_out_byte;
    assign o_byte_valid = r_out_bvalid;
    assign o_send_flow  = r_out_send;
    assign o_flow_char  = r_out_char;
    assign o_overflow   = r_out_ovf;
    assign o_fill_level = r_out_fill;

endmodule

FILE: rtl/core/byte_fifo_with_xon_xoff_watermarks_top.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_mode, i_byte_in
// output    o_out_valid / i_out_ready  o_byte_out, o_byte_valid, o_send_flow,
//                                      o_flow_char, o_overflow, o_fill_level
// config    i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Each transaction is accepted and updates the FIFO in the controller's idle
// state; the registered read of the byte store then feeds the output register.
// The next item is accepted while the previous result waits in the output
// register; a stalled output holds the controller in its result state.
// Reset is synchronous, active low; it empties the FIFO and runs the link.
// Top level of the byte FIFO; depends on bfx_pkg, bfx_ctrl and bfx_dpath.
module byte_fifo_with_xon_xoff_watermarks_top #(
    parameter int unsigned FIFO_DEPTH = bfx_pkg::DEF_FIFO_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bfx_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfx_pkg::MARK_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [bfx_pkg::BYTE_W-1:0]      i_byte_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bfx_pkg::BYTE_W-1:0]      o_byte_out,
    output logic                            o_byte_valid,
    output logic                            o_send_flow,
    output logic [bfx_pkg::BYTE_W-1:0]      o_flow_char,
    output logic                            o_overflow,
    output logic [bfx_pkg::FILL_W-1:0]      o_fill_level
);
    import bfx_pkg::*;

    t_cmd    cmd;
    t_status status;

    bfx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bfx_dpath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_mode),
        .i_byte_in    (i_byte_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_byte_out   (o_byte_out),
        .o_byte_valid (o_byte_valid),
        .o_send_flow  (o_send_flow),
        .o_flow_char  (o_flow_char),
        .o_overflow   (o_overflow),
        .o_fill_level (o_fill_level)
    );

    // One item at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // A popped byte and a dropped push never share a result
    a_pop_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_valid) |-> !o_overflow)
        else $error("result flags both byte and overflow");

    // A flow request carries XON or XOFF, otherwise no character
    a_flow_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_send_flow ? (o_flow_char == XON_CHAR ||
                                        o_flow_char == XOFF_CHAR)
                                     : (o_flow_char == '0)))
        else $error("flow character does not match send flag");

    // An empty pop or a push returns a zero byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_byte_out == '0))
        else $error("byte output not zero without a popped byte");

endmodule
